// ===== design/lskv_pkg.sv =====
// Shared constants, codes, command/status bundles and helpers for the key/value table.
package lskv_pkg;

    // Table geometry
    localparam int SLOTS       = 64;
    localparam int KEY_BYTES   = 8;
    localparam int VALUE_BYTES = 8;

    localparam int KEY_W     = 64;
    localparam int VAL_W     = 64;
    localparam int LEN_W     = 4;
    localparam int KIND_W    = 3;
    localparam int STATUS_W  = 3;
    localparam int ENTRY_W   = 7;
    localparam int ACT_W     = 7;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int WORD_W    = KEY_W + LEN_W + VAL_W + LEN_W;

    // Command kinds
    localparam logic [KIND_W-1:0] K_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] K_DELETE = 3'd1;
    localparam logic [KIND_W-1:0] K_GET    = 3'd2;
    localparam logic [KIND_W-1:0] K_UPDATE = 3'd3;
    localparam logic [KIND_W-1:0] K_CLEAR  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VAL_LIM = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_DUP       = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EMPTY_KEY = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        C_NONE   = 3'd0,
        C_INSERT = 3'd1,
        C_DELETE = 3'd2,
        C_UPDATE = 3'd3,
        C_CLEAR  = 3'd4
    } commit_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    issue;
        commit_t commit;
        logic    result_load;
        status_t result_status;
        logic    result_get;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              empty_key;
        logic              issue_done;
        logic              hit;
        logic              found;
        logic              free_found;
        logic              out_busy;
    } dp_stat_t;

    // Mask keeping the low n bytes of a 64-bit word
    function automatic logic [KEY_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (LEN_W'(b) < n)
                m[b*8 +: 8] = 8'hFF;
        end
        return m;
    endfunction

    function automatic logic [LEN_W-1:0] min_len(input logic [LEN_W-1:0] a,
                                                input logic [LEN_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

// ===== design/lskv_ram.sv =====
// Generic single-port RAM with registered read.
module lskv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata <= mem[addr];
        end
    end

endmodule

// ===== design/lskv_ctrl.sv =====
// Command sequencer: check, scan, act, deliver result.
module lskv_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lskv_pkg::dp_stat_t stat,
    output lskv_pkg::dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_SCAN   = 5'b00100,
        S_ACT    = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    lskv_pkg::status_t status_reg, status_next;
    logic              get_reg, get_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next        = state_reg;
        status_next       = status_reg;
        get_next          = get_reg;
        cmd               = '0;
        cmd.commit        = lskv_pkg::C_NONE;
        cmd.result_status = status_reg;
        cmd.result_get    = get_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    get_next   = 1'b0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                status_next = lskv_pkg::ST_OK;
                state_next  = S_FINISH;
                if (stat.kind inside {lskv_pkg::K_INSERT, lskv_pkg::K_DELETE,
                                      lskv_pkg::K_GET, lskv_pkg::K_UPDATE})
                begin
                    if (stat.empty_key)
                        status_next = lskv_pkg::ST_EMPTY_KEY;
                    else
                        state_next = S_SCAN;
                end
                else if (stat.kind == lskv_pkg::K_CLEAR)
                begin
                    cmd.commit = lskv_pkg::C_CLEAR;
                end
            end
            S_SCAN:
            begin
                cmd.issue = !stat.issue_done && !stat.hit;
                if (stat.hit || stat.issue_done)
                    state_next = S_ACT;
            end
            S_ACT:
            begin
                state_next = S_FINISH;
                case (stat.kind)
                    lskv_pkg::K_INSERT:
                    begin
                        if (stat.found)
                            status_next = lskv_pkg::ST_DUP;
                        else if (stat.free_found)
                        begin
                            status_next = lskv_pkg::ST_OK;
                            cmd.commit  = lskv_pkg::C_INSERT;
                        end
                        else
                            status_next = lskv_pkg::ST_FULL;
                    end
                    lskv_pkg::K_DELETE:
                    begin
                        if (stat.found)
                        begin
                            status_next = lskv_pkg::ST_OK;
                            cmd.commit  = lskv_pkg::C_DELETE;
                        end
                        else
                            status_next = lskv_pkg::ST_NOT_FOUND;
                    end
                    lskv_pkg::K_GET:
                    begin
                        status_next = stat.found ? lskv_pkg::ST_OK : lskv_pkg::ST_NOT_FOUND;
                        get_next    = stat.found;
                    end
                    lskv_pkg::K_UPDATE:
                    begin
                        if (stat.found)
                        begin
                            status_next = lskv_pkg::ST_OK;
                            cmd.commit  = lskv_pkg::C_UPDATE;
                        end
                        else
                            status_next = lskv_pkg::ST_NOT_FOUND;
                    end
                    default:
                    begin
                        status_next = lskv_pkg::ST_OK;
                    end
                endcase
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= lskv_pkg::ST_OK;
            get_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            get_reg    <= get_next;
        end
    end

    // Checks
    a_get_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load && cmd.result_get |-> cmd.result_status == lskv_pkg::ST_OK)
        else $error("get result without a match");

    a_commit_then_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit != lskv_pkg::C_NONE |=> state_reg == S_FINISH)
        else $error("table update not followed by result");

    a_no_issue_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
        stat.hit |-> !cmd.issue)
        else $error("scan continued past a match");

endmodule

// ===== design/lskv_dp.sv =====
// Datapath: config registers, item capture, slot scan, valid bits, count, result register.
module lskv_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lskv_pkg::dp_cmd_t                   cmd,
    output lskv_pkg::dp_stat_t                  stat,
    input  logic                                cfg_we,
    input  logic [lskv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lskv_pkg::CFG_W-1:0]          cfg_data,
    input  logic [lskv_pkg::KIND_W-1:0]         kind,
    input  logic [lskv_pkg::KEY_W-1:0]          key,
    input  logic [lskv_pkg::LEN_W-1:0]          key_len,
    input  logic [lskv_pkg::VAL_W-1:0]          value,
    input  logic [lskv_pkg::LEN_W-1:0]          value_len,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [lskv_pkg::STATUS_W-1:0]       status,
    output logic [lskv_pkg::VAL_W-1:0]          found_value,
    output logic [lskv_pkg::LEN_W-1:0]          found_value_len,
    output logic [lskv_pkg::ENTRY_W-1:0]        entry_total
);

    localparam logic [lskv_pkg::LEN_W-1:0] KEY_MAX = lskv_pkg::LEN_W'(lskv_pkg::KEY_BYTES);
    localparam logic [lskv_pkg::LEN_W-1:0] VAL_MAX = lskv_pkg::LEN_W'(lskv_pkg::VALUE_BYTES);

    // Config registers
    logic [lskv_pkg::ACT_W-1:0] active_slots_reg;
    logic [lskv_pkg::LEN_W-1:0] max_key_len_reg;
    logic [lskv_pkg::LEN_W-1:0] max_value_len_reg;

    // Captured command
    logic [lskv_pkg::KIND_W-1:0] kind_reg;
    logic                        empty_reg;
    logic [lskv_pkg::KEY_W-1:0]  skey_reg;
    logic [lskv_pkg::LEN_W-1:0]  slen_reg;
    logic [lskv_pkg::VAL_W-1:0]  wval_reg;
    logic [lskv_pkg::LEN_W-1:0]  wvlen_reg;
    logic [lskv_pkg::CNT_W-1:0]  lim_reg;

    // Scan state
    logic [lskv_pkg::CNT_W-1:0]  idx_reg;
    logic                        cmp_valid_reg;
    logic [lskv_pkg::IDX_W-1:0]  cmp_idx_reg;
    logic                        found_reg;
    logic [lskv_pkg::IDX_W-1:0]  hit_idx_reg;
    logic [lskv_pkg::VAL_W-1:0]  hit_val_reg;
    logic [lskv_pkg::LEN_W-1:0]  hit_vlen_reg;
    logic                        free_found_reg;
    logic [lskv_pkg::IDX_W-1:0]  free_idx_reg;

    // Table occupancy
    logic [lskv_pkg::SLOTS-1:0]  valid_reg;
    logic [lskv_pkg::CNT_W-1:0]  count_reg;

    // Result register
    logic                         out_valid_reg;
    logic [lskv_pkg::STATUS_W-1:0] status_reg;
    logic [lskv_pkg::VAL_W-1:0]   fval_reg;
    logic [lskv_pkg::LEN_W-1:0]   flen_reg;
    logic [lskv_pkg::ENTRY_W-1:0] total_reg;

    // Input length handling
    logic [lskv_pkg::LEN_W-1:0] klen_sat, vlen_sat, klim, vlim, tklen, tvlen;
    logic [lskv_pkg::KEY_W-1:0] k_masked;
    logic [lskv_pkg::CNT_W-1:0] lim_calc;

    always_comb
    begin
        klen_sat = lskv_pkg::min_len(key_len, KEY_MAX);
        vlen_sat = lskv_pkg::min_len(value_len, VAL_MAX);
        klim     = lskv_pkg::min_len(max_key_len_reg, KEY_MAX);
        if (klim == '0)
            klim = lskv_pkg::LEN_W'(1);
        vlim     = lskv_pkg::min_len(max_value_len_reg, VAL_MAX);
        tklen    = lskv_pkg::min_len(klen_sat, klim);
        tvlen    = lskv_pkg::min_len(vlen_sat, vlim);
        k_masked = key & lskv_pkg::byte_mask(klen_sat);
        if (32'(active_slots_reg) > lskv_pkg::SLOTS)
            lim_calc = lskv_pkg::CNT_W'(lskv_pkg::SLOTS);
        else
            lim_calc = lskv_pkg::CNT_W'(active_slots_reg);
    end

    // Slot memory: key, key length, value, value length
    logic                        ram_en, ram_we;
    logic [lskv_pkg::IDX_W-1:0]  ram_addr;
    logic [lskv_pkg::WORD_W-1:0] ram_wdata, ram_rdata;
    logic [lskv_pkg::KEY_W-1:0]  rd_key;
    logic [lskv_pkg::LEN_W-1:0]  rd_klen;
    logic [lskv_pkg::VAL_W-1:0]  rd_val;
    logic [lskv_pkg::LEN_W-1:0]  rd_vlen;
    logic                        mem_write;

    assign mem_write = (cmd.commit == lskv_pkg::C_INSERT) || (cmd.commit == lskv_pkg::C_UPDATE);
    assign ram_we    = mem_write;
    assign ram_en    = mem_write || cmd.issue;
    assign ram_addr  = (cmd.commit == lskv_pkg::C_INSERT) ? free_idx_reg :
                       (cmd.commit == lskv_pkg::C_UPDATE) ? hit_idx_reg :
                       idx_reg[lskv_pkg::IDX_W-1:0];
    assign ram_wdata = {skey_reg, slen_reg, wval_reg, wvlen_reg};
    assign {rd_key, rd_klen, rd_val, rd_vlen} = ram_rdata;

    lskv_ram #(
        .WIDTH (lskv_pkg::WORD_W),
        .DEPTH (lskv_pkg::SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Compare stage
    logic hit, free_hit;
    assign hit      = cmp_valid_reg && valid_reg[cmp_idx_reg] &&
                      (rd_klen == slen_reg) && (rd_key == skey_reg);
    assign free_hit = cmp_valid_reg && !valid_reg[cmp_idx_reg] && !free_found_reg;

    // Config write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_slots_reg  <= lskv_pkg::ACT_W'(64);
            max_key_len_reg   <= lskv_pkg::LEN_W'(8);
            max_value_len_reg <= lskv_pkg::LEN_W'(8);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lskv_pkg::CFG_ACTIVE:  active_slots_reg  <= cfg_data;
                lskv_pkg::CFG_KEY_LIM: max_key_len_reg   <= cfg_data[lskv_pkg::LEN_W-1:0];
                lskv_pkg::CFG_VAL_LIM: max_value_len_reg <= cfg_data[lskv_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Item capture; insert searches and stores the truncated key
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind;
            empty_reg <= (klen_sat == '0);
            if (kind == lskv_pkg::K_INSERT)
            begin
                skey_reg <= k_masked & lskv_pkg::byte_mask(tklen);
                slen_reg <= tklen;
            end
            else
            begin
                skey_reg <= k_masked;
                slen_reg <= klen_sat;
            end
            wval_reg  <= value & lskv_pkg::byte_mask(tvlen);
            wvlen_reg <= tvlen;
            lim_reg   <= lim_calc;
        end
    end

    // Scan pipeline: address issue, then compare in the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            cmp_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            idx_reg        <= '0;
            cmp_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmd.issue;
            if (cmd.issue)
                idx_reg <= idx_reg + lskv_pkg::CNT_W'(1);
            if (hit)
                found_reg <= 1'b1;
            if (free_hit)
                free_found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
            cmp_idx_reg <= idx_reg[lskv_pkg::IDX_W-1:0];
        if (hit)
        begin
            hit_idx_reg  <= cmp_idx_reg;
            hit_val_reg  <= rd_val;
            hit_vlen_reg <= rd_vlen;
        end
        if (free_hit)
            free_idx_reg <= cmp_idx_reg;
    end

    // Valid bits and occupancy count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            case (cmd.commit)
                lskv_pkg::C_INSERT:
                begin
                    valid_reg[free_idx_reg] <= 1'b1;
                    count_reg <= count_reg + lskv_pkg::CNT_W'(1);
                end
                lskv_pkg::C_DELETE:
                begin
                    valid_reg[hit_idx_reg] <= 1'b0;
                    if (count_reg != '0)
                        count_reg <= count_reg - lskv_pkg::CNT_W'(1);
                end
                lskv_pkg::C_CLEAR:
                begin
                    valid_reg <= '0;
                    count_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.result_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            status_reg <= cmd.result_status;
            fval_reg   <= cmd.result_get ? hit_val_reg : '0;
            flen_reg   <= cmd.result_get ? hit_vlen_reg : '0;
            total_reg  <= lskv_pkg::ENTRY_W'(count_reg);
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign found_value     = fval_reg;
    assign found_value_len = flen_reg;
    assign entry_total     = total_reg;

    // Status to controller
    always_comb
    begin
        stat.kind       = kind_reg;
        stat.empty_key  = empty_reg;
        stat.issue_done = (idx_reg >= lim_reg);
        stat.hit        = hit;
        stat.found      = found_reg;
        stat.free_found = free_found_reg;
        stat.out_busy   = out_valid_reg && !out_ready;
    end

    // Checks
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(count_reg))
        else $error("occupancy count out of step with valid bits");

    a_insert_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit == lskv_pkg::C_INSERT |-> !valid_reg[free_idx_reg])
        else $error("insert into an occupied slot");

    a_delete_valid_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit == lskv_pkg::C_DELETE |-> valid_reg[hit_idx_reg] && found_reg)
        else $error("delete of a slot that did not match");

endmodule

// ===== design/linear_scan_key_value_table.sv =====
// Key/value table top level: a linear-scan store of up to 64 key/value slots.
//
// Each command beat (insert, delete, get, update, clear all) yields one result
// beat. Lookups walk slots 0 to n-1, n = min(active_slots, 64), through a
// single-port slot memory, one slot per cycle, and a match ends the scan
// early. Clear all, empty-key and unknown commands skip the scan. The next
// command can be accepted from the cycle in which the result is registered.
// A finished result sits in an output register while the next command is
// accepted; a result still held by out_ready low keeps the next one, and so
// the next command, waiting. Slot validity is held in flip-flops that reset
// clears at once, so no clearing pass runs after reset.
module linear_scan_key_value_table (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [lskv_pkg::KIND_W-1:0]     kind,
    input  logic [lskv_pkg::KEY_W-1:0]      key,
    input  logic [lskv_pkg::LEN_W-1:0]      key_len,
    input  logic [lskv_pkg::VAL_W-1:0]      value,
    input  logic [lskv_pkg::LEN_W-1:0]      value_len,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [lskv_pkg::STATUS_W-1:0]   status,
    output logic [lskv_pkg::VAL_W-1:0]      found_value,
    output logic [lskv_pkg::LEN_W-1:0]      found_value_len,
    output logic [lskv_pkg::ENTRY_W-1:0]    entry_total,
    input  logic                            cfg_we,
    input  logic [lskv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lskv_pkg::CFG_W-1:0]      cfg_data
);

    lskv_pkg::dp_cmd_t  cmd;
    lskv_pkg::dp_stat_t stat;

    lskv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lskv_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .kind            (kind),
        .key             (key),
        .key_len         (key_len),
        .value           (value),
        .value_len       (value_len),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .status          (status),
        .found_value     (found_value),
        .found_value_len (found_value_len),
        .entry_total     (entry_total)
    );

endmodule
